>>> rtl/core/owbm_pkg.sv
// owbm_pkg: shared types, codes and timing constants of the 1-Wire bus master
// used by owbm_step and one_wire_bus_master; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

    // action codes of an input item
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // operation codes
    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // slot phase codes
    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_MID  = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;

    // phase lengths in ticks
    localparam logic [8:0] T_RST_LOW  = 9'd481;
    localparam logic [8:0] T_RST_WAIT = 9'd80;
    localparam logic [8:0] T_RST_TAIL = 9'd400;
    localparam logic [8:0] T_SLOT     = 9'd60;
    localparam logic [8:0] T_W1_LOW   = 9'd1;
    localparam logic [8:0] T_RD_LOW   = 9'd2;
    localparam logic [8:0] T_RD_REL   = 9'd2;

    // sequencer state
    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] slot_phase;
        logic [8:0] phase_timer;
        logic [2:0] bit_index;
        logic [7:0] shift_byte;
        logic       presence_flag;
        logic       drive_state;
        logic [7:0] read_reg;
    } t_owbm_state;

endpackage

`default_nettype wire

>>> rtl/core/owbm_step.sv
// owbm_step: next-state logic of the bus sequencer for one item
// depends on owbm_pkg
`timescale 1ns / 1ps
`default_nettype none

module owbm_step (
    input  owbm_pkg::t_owbm_state i_cur,
    input  logic [1:0]            i_action,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_line_level,
    output owbm_pkg::t_owbm_state o_nxt,
    output logic                  o_done
);
    import owbm_pkg::*;

    logic [8:0] t_dec;
    logic [2:0] bit_inc;
    logic       cur_bit;
    logic       nxt_bit;
    logic       last_bit;

    // bit selects for the current and the following slot
    assign t_dec    = (i_cur.phase_timer != 9'd0) ? i_cur.phase_timer - 9'd1 : 9'd0;
    assign bit_inc  = i_cur.bit_index + 3'd1;
    assign cur_bit  = i_cur.shift_byte[i_cur.bit_index];
    assign nxt_bit  = i_cur.shift_byte[bit_inc];
    assign last_bit = (i_cur.bit_index == 3'd7);

    // sequencer update
    always_comb begin
        o_nxt  = i_cur;
        o_done = 1'b0;
        if (i_action != ACT_TICK) begin
            // command, taken only while idle
            if (i_cur.operation == OP_IDLE) begin
                o_nxt.bit_index   = 3'd0;
                o_nxt.slot_phase  = PH_LOW;
                o_nxt.drive_state = 1'b1;
                unique case (i_action)
                    ACT_RESET: begin
                        o_nxt.operation   = OP_RESET;
                        o_nxt.phase_timer = T_RST_LOW;
                    end
                    ACT_WRITE: begin
                        o_nxt.operation   = OP_WRITE;
                        o_nxt.shift_byte  = i_data_byte;
                        o_nxt.phase_timer = i_data_byte[0] ? T_W1_LOW : T_SLOT;
                    end
                    default: begin
                        o_nxt.operation   = OP_READ;
                        o_nxt.shift_byte  = 8'd0;
                        o_nxt.phase_timer = T_RD_LOW;
                    end
                endcase
            end
        end else if (i_cur.operation != OP_IDLE) begin
            // tick: count down, act at the end of a phase
            o_nxt.phase_timer = t_dec;
            if (t_dec == 9'd0) begin
                unique case (i_cur.operation)
                    OP_RESET: begin
                        case (i_cur.slot_phase)
                            PH_LOW: begin
                                o_nxt.slot_phase  = PH_MID;
                                o_nxt.drive_state = 1'b0;
                                o_nxt.phase_timer = T_RST_WAIT;
                            end
                            PH_MID: begin
                                o_nxt.presence_flag = ~i_line_level;
                                o_nxt.slot_phase    = PH_TAIL;
                                o_nxt.drive_state   = 1'b0;
                                o_nxt.phase_timer   = T_RST_TAIL;
                            end
                            default: begin
                                o_nxt.operation   = OP_IDLE;
                                o_nxt.slot_phase  = PH_LOW;
                                o_nxt.drive_state = 1'b0;
                                o_nxt.phase_timer = 9'd0;
                                o_done            = 1'b1;
                            end
                        endcase
                    end
                    default: begin
                        // write and read slots
                        if (i_cur.operation == OP_WRITE && i_cur.slot_phase == PH_LOW
                                && cur_bit) begin
                            o_nxt.slot_phase  = PH_MID;
                            o_nxt.drive_state = 1'b0;
                            o_nxt.phase_timer = T_SLOT;
                        end else if (i_cur.operation == OP_READ
                                && i_cur.slot_phase == PH_LOW) begin
                            o_nxt.slot_phase  = PH_MID;
                            o_nxt.drive_state = 1'b0;
                            o_nxt.phase_timer = T_RD_REL;
                        end else if (i_cur.operation == OP_READ
                                && i_cur.slot_phase == PH_MID) begin
                            if (i_line_level) begin
                                o_nxt.shift_byte[i_cur.bit_index] = 1'b1;
                            end
                            o_nxt.slot_phase  = PH_TAIL;
                            o_nxt.drive_state = 1'b0;
                            o_nxt.phase_timer = T_SLOT;
                        end else if (last_bit) begin
                            // end of byte
                            if (i_cur.operation == OP_READ) begin
                                o_nxt.read_reg = i_cur.shift_byte;
                            end
                            o_nxt.operation   = OP_IDLE;
                            o_nxt.bit_index   = 3'd0;
                            o_nxt.slot_phase  = PH_LOW;
                            o_nxt.drive_state = 1'b0;
                            o_nxt.phase_timer = 9'd0;
                            o_done            = 1'b1;
                        end else begin
                            // next slot starts at once
                            o_nxt.bit_index   = bit_inc;
                            o_nxt.slot_phase  = PH_LOW;
                            o_nxt.drive_state = 1'b1;
                            if (i_cur.operation == OP_WRITE) begin
                                o_nxt.phase_timer = nxt_bit ? T_W1_LOW : T_SLOT;
                            end else begin
                                o_nxt.phase_timer = T_RD_LOW;
                            end
                        end
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/one_wire_bus_master.sv
// one_wire_bus_master: 1-Wire bus master stepped by one-microsecond tick items
// depends on owbm_pkg and owbm_step
//
//   channel | signals                                    | direction
//   in      | i_in_valid/o_in_ready, action, data, line  | item in
//   out     | o_out_valid/i_out_ready, drive, busy, done,| result out
//           | presence, read_data                        |
//
// One item per cycle while results are taken: the sequencer state and the result register
// update on the edge that takes the item, so each result appears in the next cycle.
// The result register frees itself when taken, so a new item is accepted in
// the same cycle a waiting result leaves; only an untaken result stalls input.
// i_rst_n (synchronous, active low) returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic       i_line_level,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_drive_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_presence,
    output logic [7:0] o_read_data
);
    import owbm_pkg::*;

    t_owbm_state r_state;
    t_owbm_state n_state;
    logic        step_done;
    logic        in_take;
    logic        r_out_valid;
    logic        r_drive_low;
    logic        r_busy_res;
    logic        r_done_res;
    logic        r_presence;
    logic [7:0]  r_read_data;

    // handshake
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_take    = i_in_valid & o_in_ready;

    // next-state logic
    owbm_step u_step (
        .i_cur        (r_state),
        .i_action     (i_action),
        .i_data_byte  (i_data_byte),
        .i_line_level (i_line_level),
        .o_nxt        (n_state),
        .o_done       (step_done)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_drive_low <= n_state.drive_state;
            r_busy_res  <= (n_state.operation != OP_IDLE);
            r_done_res  <= step_done;
            r_presence  <= n_state.presence_flag;
            r_read_data <= n_state.read_reg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive_low = r_drive_low;
    assign o_busy_res  = r_busy_res;
    assign o_done_res  = r_done_res;
    assign o_presence  = r_presence;
    assign o_read_data = r_read_data;

endmodule

`default_nettype wire

>>> verif/owbm_result_checker.sv
// owbm_result_checker: watches both item channels of one_wire_bus_master,
// predicts every result item from the accepted input items and compares them
// depends on owbm_pkg for action, operation, phase codes and slot timing
`timescale 1ns / 1ps

module owbm_result_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic       i_line_level,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_drive_low,
    input  logic       i_busy_res,
    input  logic       i_done_res,
    input  logic       i_presence,
    input  logic [7:0] i_read_data,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_checked,
    output int         o_sequences
);
    import owbm_pkg::*;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_byte;
    } t_bus_result;

    // predicted bus master state
    logic [1:0] bus_op;
    logic [1:0] phase;
    logic [8:0] phase_left;
    logic [2:0] bit_pos;
    logic [7:0] byte_sr;
    logic       presence_q;
    logic       pull_low;
    logic [7:0] last_read;

    t_bus_result pending_results[$];

    function automatic void clear_bus_state();
        bus_op     = OP_IDLE;
        phase      = PH_LOW;
        phase_left = '0;
        bit_pos    = '0;
        byte_sr    = '0;
        presence_q = 1'b0;
        pull_low   = 1'b0;
        last_read  = '0;
    endfunction

    function automatic void enter_phase(logic [1:0] ph, logic low, logic [8:0] len);
        phase      = ph;
        pull_low   = low;
        phase_left = len;
    endfunction

    // every slot opens with the line pulled low
    function automatic void arm_slot();
        if (bus_op == OP_WRITE) begin
            enter_phase(PH_LOW, 1'b1, byte_sr[bit_pos] ? T_W1_LOW : T_SLOT);
        end else begin
            enter_phase(PH_LOW, 1'b1, T_RD_LOW);
        end
    endfunction

    // move to the next bit slot, or close the byte after the eighth
    function automatic logic next_slot();
        if (bit_pos == 3'd7) begin
            if (bus_op == OP_READ) begin
                last_read = byte_sr;
            end
            bus_op  = OP_IDLE;
            bit_pos = '0;
            enter_phase(PH_LOW, 1'b0, '0);
            return 1'b1;
        end
        bit_pos = bit_pos + 3'd1;
        arm_slot();
        return 1'b0;
    endfunction

    function automatic t_bus_result predict_bus_result(logic [1:0] action, logic [7:0] data,
                                                       logic lvl);
        logic        finished;
        t_bus_result res;
        finished = 1'b0;
        if (action != ACT_TICK) begin
            // commands only start something when idle
            if (bus_op == OP_IDLE) begin
                bit_pos = '0;
                case (action)
                    ACT_RESET: begin
                        bus_op = OP_RESET;
                        enter_phase(PH_LOW, 1'b1, T_RST_LOW);
                    end
                    ACT_WRITE: begin
                        bus_op  = OP_WRITE;
                        byte_sr = data;
                        arm_slot();
                    end
                    default: begin
                        bus_op  = OP_READ;
                        byte_sr = '0;
                        arm_slot();
                    end
                endcase
            end
        end else if (bus_op != OP_IDLE) begin
            if (phase_left != '0) begin
                phase_left = phase_left - 9'd1;
            end
            if (phase_left == '0) begin
                case (bus_op)
                    OP_RESET: begin
                        case (phase)
                            PH_LOW: enter_phase(PH_MID, 1'b0, T_RST_WAIT);
                            PH_MID: begin
                                // a device answers by holding the line low
                                presence_q = ~lvl;
                                enter_phase(PH_TAIL, 1'b0, T_RST_TAIL);
                            end
                            default: begin
                                bus_op = OP_IDLE;
                                enter_phase(PH_LOW, 1'b0, '0);
                                finished = 1'b1;
                            end
                        endcase
                    end
                    OP_WRITE: begin
                        // a one releases after its short low, a zero ends with no gap
                        if (phase == PH_LOW && byte_sr[bit_pos]) begin
                            enter_phase(PH_MID, 1'b0, T_SLOT);
                        end else begin
                            finished = next_slot();
                        end
                    end
                    default: begin
                        case (phase)
                            PH_LOW: enter_phase(PH_MID, 1'b0, T_RD_REL);
                            PH_MID: begin
                                if (lvl) begin
                                    byte_sr[bit_pos] = 1'b1;
                                end
                                enter_phase(PH_TAIL, 1'b0, T_SLOT);
                            end
                            default: finished = next_slot();
                        endcase
                    end
                endcase
            end
        end
        if (finished) begin
            o_sequences++;
        end
        res.drive_low = pull_low;
        res.busy      = (bus_op != OP_IDLE);
        res.done      = finished;
        res.presence  = presence_q;
        res.read_byte = last_read;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        o_mismatches++;
        $display("mismatch at %0t, result %0d: %s got %0h expected %0h",
                 $time, o_checked, what, got, want);
    endtask

    // compare leaving results, then queue the prediction for the accepted item
    always @(posedge i_clk) begin
        t_bus_result got;
        t_bus_result want;
        if (!i_rst_n) begin
            clear_bus_state();
            pending_results.delete();
            o_mismatches = 0;
            o_pending    = 0;
            o_checked    = 0;
            o_sequences  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_drive_low, i_busy_res, i_done_res, i_presence, i_read_data};
                if (pending_results.size() == 0) begin
                    report_mismatch("result item with none expected", '0, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.drive_low !== want.drive_low)
                        report_mismatch("drive_low", {7'd0, got.drive_low},
                                        {7'd0, want.drive_low});
                    if (got.busy !== want.busy)
                        report_mismatch("busy_res", {7'd0, got.busy}, {7'd0, want.busy});
                    if (got.done !== want.done)
                        report_mismatch("done_res", {7'd0, got.done}, {7'd0, want.done});
                    if (got.presence !== want.presence)
                        report_mismatch("presence", {7'd0, got.presence},
                                        {7'd0, want.presence});
                    if (got.read_byte !== want.read_byte)
                        report_mismatch("read_data", got.read_byte, want.read_byte);
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(
                    predict_bus_result(i_action, i_data_byte, i_line_level));
            end
            o_pending = pending_results.size();
        end
    end

endmodule

>>> verif/tb_one_wire_bus_master.sv
// tb_one_wire_bus_master: drives ticks and bus commands into one_wire_bus_master
// with random gaps and output stalls; owbm_result_checker does the comparing
// depends on owbm_pkg, one_wire_bus_master and owbm_result_checker
`timescale 1ns / 1ps

module tb_one_wire_bus_master;
    import owbm_pkg::*;

    localparam int NOISE_PCT   = 2;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 8;

    typedef enum logic [1:0] {LINE_LOW, LINE_HIGH, LINE_RAND} t_line_mode;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] in_action = ACT_TICK;
    logic [7:0] in_data   = '0;
    logic       in_line   = 1'b1;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;

    int mismatches;
    int pending;
    int checked;
    int sequences;

    // stimulus bookkeeping: ticks until the block is idle again
    int ticks_left    = 0;
    int sent_items    = 0;
    int counted_items = 0;
    int ignored_items = 0;
    int idle_cycles   = 0;
    bit calm_in       = 1'b0;
    bit calm_out      = 1'b0;

    one_wire_bus_master dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_action    (in_action),
        .i_data_byte (in_data),
        .i_line_level(in_line),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_drive_low (drive_low),
        .o_busy_res  (busy_res),
        .o_done_res  (done_res),
        .o_presence  (presence),
        .o_read_data (read_data)
    );

    owbm_result_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_action    (in_action),
        .i_data_byte (in_data),
        .i_line_level(in_line),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_drive_low (drive_low),
        .i_busy_res  (busy_res),
        .i_done_res  (done_res),
        .i_presence  (presence),
        .i_read_data (read_data),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_sequences (sequences)
    );

    // 4 ns clock
    initial begin
        forever #2 clk = ~clk;
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return ACT_RESET;
        end
        if (r < 60) begin
            return ACT_WRITE;
        end
        return ACT_READ;
    endfunction

    function automatic logic tick_line(t_line_mode mode);
        case (mode)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            default:   return 1'($urandom);
        endcase
    endfunction

    // ticks a command keeps the block busy, from the bus timing
    function automatic int seq_ticks(logic [1:0] act, logic [7:0] data);
        int total;
        total = 0;
        case (act)
            ACT_RESET: total = int'(T_RST_LOW) + int'(T_RST_WAIT) + int'(T_RST_TAIL);
            ACT_WRITE: begin
                for (int b = 0; b < 8; b++) begin
                    total += data[b] ? int'(T_W1_LOW) + int'(T_SLOT) : int'(T_SLOT);
                end
            end
            ACT_READ: total = 8 * (int'(T_RD_LOW) + int'(T_RD_REL) + int'(T_SLOT));
            default: total = 0;
        endcase
        return total;
    endfunction

    // offer one input item and wait for it to be taken
    task automatic send_item(logic [1:0] act, logic [7:0] data, logic lvl);
        int gap;
        gap = pick_gap(calm_in);
        if ($urandom_range(0, 199) == 0) begin
            calm_in = ~calm_in;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_data   <= data;
        in_line   <= lvl;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        sent_items++;
        if (act == ACT_TICK) begin
            if (ticks_left > 0) begin
                ticks_left--;
                counted_items++;
            end else begin
                ignored_items++;
            end
        end else if (ticks_left == 0) begin
            ticks_left = seq_ticks(act, data);
            counted_items++;
        end else begin
            ignored_items++;
        end
    endtask

    // tick the running sequence to its end, with stray commands mixed in
    task automatic drain_ticks(t_line_mode mode, int noise_pct);
        while (ticks_left > 0) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_item(pick_command(), 8'($urandom), 1'($urandom));
            end
            send_item(ACT_TICK, 8'($urandom), tick_line(mode));
        end
    endtask

    task automatic run_sequence(logic [1:0] act, logic [7:0] data, t_line_mode mode,
                                int noise_pct);
        send_item(act, data, 1'($urandom));
        drain_ticks(mode, noise_pct);
    endtask

    // output side stalls
    initial begin
        @(posedge clk);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if ($urandom_range(0, 39) == 0) begin
                calm_out = ~calm_out;
            end
            if (pick_gap(calm_out) > 0) begin
                out_ready <= 1'b0;
                repeat (pick_gap(1'b0) + 1) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks change nothing
        send_item(ACT_TICK, 8'hFF, 1'b1);
        send_item(ACT_TICK, 8'h00, 1'b0);
        // reset with a device answering
        run_sequence(ACT_RESET, 8'h00, LINE_LOW, 0);
        // mixed write byte, commands back to back while busy are ignored
        send_item(ACT_WRITE, 8'hA5, 1'b1);
        send_item(ACT_RESET, 8'h00, 1'b0);
        send_item(ACT_WRITE, 8'h3C, 1'b1);
        send_item(ACT_READ, 8'hFF, 1'b0);
        drain_ticks(LINE_RAND, NOISE_PCT);
        // read gathering random bus levels, started right after the write
        run_sequence(ACT_READ, 8'($urandom), LINE_RAND, NOISE_PCT);
        // idle tick after the last sequence
        send_item(ACT_TICK, 8'($urandom), 1'($urandom));
        in_valid <= 1'b0;

        // drain the results still on their way
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("sent %0d input items: %0d effective, %0d ignored, %0d results checked",
                 sent_items, counted_items, ignored_items, checked);
        $display("bus sequences completed: %0d, mismatches: %0d", sequences, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
